@@ rtl/core/mosaic_tile_pixel_mapper_core_assert.svh @@
// Assertion macros shared by the mosaic tile pixel mapper checkers.
`ifndef MOSAIC_TILE_PIXEL_MAPPER_CORE_ASSERT_SVH
`define MOSAIC_TILE_PIXEL_MAPPER_CORE_ASSERT_SVH

// Plain clocked property with an active-low reset that disables it.
`define MTPM_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("mtpm assertion failed");

// Clocked implication from a condition to a consequence in the same cycle.
`define MTPM_ASSERT_IMPLIES(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("mtpm implication failed");

`endif

@@ rtl/core/mtpm_pkg.sv @@
// Shared constants, register codes and stage types of the mosaic tile pixel mapper.
package mtpm_pkg;

  localparam int unsigned MAX_TILES_PER_AXIS = 16;
  localparam int unsigned MAX_TILE_SIZE      = 4096;
  localparam int unsigned MIN_TILE_SIZE      = 2;

  localparam int unsigned COORD_W    = 16;
  localparam int unsigned SIZE_W     = 13;
  localparam int unsigned OV_W       = 12;
  localparam int unsigned CNT_W      = 5;
  localparam int unsigned IDX_W      = 4;
  localparam int unsigned HALF_W     = 11;
  localparam int unsigned OFF_W      = 12;
  localparam int unsigned TOTAL_W    = 17;
  localparam int unsigned BOUND_W    = 17;
  localparam int unsigned NUM_W      = 8;
  localparam int unsigned SIDX_W     = 24;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 13;
  localparam int unsigned NUM_BOUNDS = MAX_TILES_PER_AXIS - 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TILE_WIDTH   = 3'd0,
    CFG_TILE_HEIGHT  = 3'd1,
    CFG_OVERLAP_H    = 3'd2,
    CFG_OVERLAP_V    = 3'd3,
    CFG_COLUMNS      = 3'd4,
    CFG_ROWS         = 3'd5
  } cfg_reg_e;

  // Effective settings of one axis, derived from the raw registers.
  typedef struct packed {
    logic [SIZE_W-1:0]                  size;
    logic [HALF_W-1:0]                  half;
    logic [SIZE_W-1:0]                  pitch;
    logic [CNT_W-1:0]                   count;
    logic [TOTAL_W-1:0]                 total;
    logic [NUM_BOUNDS-1:0][BOUND_W-1:0] bound;
  } axis_cfg_t;

  typedef struct packed {
    logic [IDX_W-1:0]   idx;
    logic [COORD_W-1:0] coord;
    logic               outside;
  } axis_s1_t;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [OFF_W-1:0] off;
    logic             outside;
  } axis_res_t;

  typedef struct packed {
    logic [IDX_W-1:0]  tile_column;
    logic [IDX_W-1:0]  tile_row;
    logic [NUM_W-1:0]  tile_number;
    logic [OFF_W-1:0]  source_x;
    logic [OFF_W-1:0]  source_y;
    logic [SIDX_W-1:0] source_index;
    logic              outside_mosaic;
  } result_t;

endpackage

@@ rtl/core/mtpm_axis_cfg.sv @@
// Derives the effective size, pitch, total and tile boundaries of one axis.
module mtpm_axis_cfg (
  input  logic                                clk_i,
  input  logic [mtpm_pkg::SIZE_W-1:0]         size_raw_i,
  input  logic [mtpm_pkg::OV_W-1:0]           ov_raw_i,
  input  logic [mtpm_pkg::CNT_W-1:0]          count_raw_i,
  output mtpm_pkg::axis_cfg_t                 cfg_o
);

  mtpm_pkg::axis_cfg_t cfg_d, cfg_q;

  always_comb begin
    logic [mtpm_pkg::SIZE_W-1:0] size_eff;
    logic [mtpm_pkg::SIZE_W-1:0] ov_ext;
    logic [mtpm_pkg::SIZE_W-1:0] ov_eff;
    logic [mtpm_pkg::CNT_W-1:0]  count_eff;
    size_eff = size_raw_i;
    if (size_raw_i < mtpm_pkg::SIZE_W'(mtpm_pkg::MIN_TILE_SIZE)) begin
      size_eff = mtpm_pkg::SIZE_W'(mtpm_pkg::MIN_TILE_SIZE);
    end else if (size_raw_i > mtpm_pkg::SIZE_W'(mtpm_pkg::MAX_TILE_SIZE)) begin
      size_eff = mtpm_pkg::SIZE_W'(mtpm_pkg::MAX_TILE_SIZE);
    end
    ov_ext = mtpm_pkg::SIZE_W'(ov_raw_i);
    ov_eff = (ov_ext < size_eff) ? ov_ext : size_eff - 1'b1;
    count_eff = count_raw_i;
    if (count_raw_i == '0) begin
      count_eff = mtpm_pkg::CNT_W'(1);
    end else if (count_raw_i > mtpm_pkg::CNT_W'(mtpm_pkg::MAX_TILES_PER_AXIS)) begin
      count_eff = mtpm_pkg::CNT_W'(mtpm_pkg::MAX_TILES_PER_AXIS);
    end
    cfg_d.size  = size_eff;
    cfg_d.half  = mtpm_pkg::HALF_W'(ov_eff >> 1);
    cfg_d.pitch = size_eff - mtpm_pkg::SIZE_W'(cfg_d.half);
    cfg_d.count = count_eff;
    cfg_d.total = mtpm_pkg::TOTAL_W'(count_eff) * mtpm_pkg::TOTAL_W'(size_eff)
                - mtpm_pkg::TOTAL_W'(count_eff - 1'b1) * mtpm_pkg::TOTAL_W'(ov_eff);
    // Boundary k holds the first coordinate of tile k+1, for k from zero up.
    for (int k = 0; k < mtpm_pkg::NUM_BOUNDS; k++) begin
      cfg_d.bound[k] = mtpm_pkg::BOUND_W'(k + 1) * mtpm_pkg::BOUND_W'(cfg_d.pitch);
    end
  end

  always_ff @(posedge clk_i) begin
    cfg_q <= cfg_d;
  end

  assign cfg_o = cfg_q;

endmodule

@@ rtl/core/mtpm_axis_map.sv @@
// Two pipeline stages of one axis: tile index by boundary compare, then offset.
module mtpm_axis_map (
  input  logic                        clk_i,
  input  mtpm_pkg::axis_cfg_t         cfg_i,
  input  logic [mtpm_pkg::COORD_W-1:0] coord_i,
  output mtpm_pkg::axis_res_t         res_o
);

  mtpm_pkg::axis_s1_t  s1_d, s1_q;
  mtpm_pkg::axis_res_t res_d, res_q;

  // The boundaries rise with k, so the passed ones form a thermometer code.
  always_comb begin
    logic [mtpm_pkg::NUM_BOUNDS-1:0] ge;
    for (int k = 0; k < mtpm_pkg::NUM_BOUNDS; k++) begin
      ge[k] = (mtpm_pkg::CNT_W'(k + 1) < cfg_i.count) &&
              (mtpm_pkg::BOUND_W'(coord_i) >= cfg_i.bound[k]);
    end
    s1_d.idx     = mtpm_pkg::IDX_W'($countones(ge));
    s1_d.coord   = coord_i;
    s1_d.outside = mtpm_pkg::TOTAL_W'(coord_i) >= cfg_i.total;
  end

  always_comb begin
    logic [mtpm_pkg::IDX_W-1:0]   bsel;
    logic [mtpm_pkg::BOUND_W-1:0] base;
    logic [mtpm_pkg::BOUND_W-1:0] off_full;
    logic [mtpm_pkg::BOUND_W-1:0] off_max;
    bsel = s1_q.idx - 1'b1;
    base = '0;
    off_full = mtpm_pkg::BOUND_W'(s1_q.coord);
    if (s1_q.idx != '0) begin
      base = cfg_i.bound[bsel];
      off_full = mtpm_pkg::BOUND_W'(s1_q.coord) - base + mtpm_pkg::BOUND_W'(cfg_i.half);
    end
    // Past the last tile the offset saturates at the tile's last pixel.
    off_max = mtpm_pkg::BOUND_W'(cfg_i.size - 1'b1);
    if (off_full > off_max) begin
      off_full = off_max;
    end
    res_d.idx     = s1_q.idx;
    res_d.off     = off_full[mtpm_pkg::OFF_W-1:0];
    res_d.outside = s1_q.outside;
  end

  always_ff @(posedge clk_i) begin
    s1_q  <= s1_d;
    res_q <= res_d;
  end

  assign res_o = res_q;

endmodule

@@ rtl/core/mtpm_index.sv @@
// Final stage: tile number, linear source index and the outside flag.
module mtpm_index (
  input  logic                 clk_i,
  input  mtpm_pkg::axis_res_t  x_i,
  input  mtpm_pkg::axis_res_t  y_i,
  input  mtpm_pkg::axis_cfg_t  cfg_x_i,
  output mtpm_pkg::result_t    res_o
);

  mtpm_pkg::result_t res_d, res_q;

  always_comb begin
    logic [mtpm_pkg::NUM_W+1:0]  num_full;
    logic [mtpm_pkg::SIDX_W:0]   idx_full;
    num_full = ((mtpm_pkg::NUM_W+2)'(y_i.idx) * (mtpm_pkg::NUM_W+2)'(cfg_x_i.count))
             + (mtpm_pkg::NUM_W+2)'(x_i.idx);
    idx_full = ((mtpm_pkg::SIDX_W+1)'(y_i.off) * (mtpm_pkg::SIDX_W+1)'(cfg_x_i.size))
             + (mtpm_pkg::SIDX_W+1)'(x_i.off);
    res_d.tile_column    = x_i.idx;
    res_d.tile_row       = y_i.idx;
    res_d.tile_number    = num_full[mtpm_pkg::NUM_W-1:0];
    res_d.source_x       = x_i.off;
    res_d.source_y       = y_i.off;
    res_d.source_index   = idx_full[mtpm_pkg::SIDX_W-1:0];
    res_d.outside_mosaic = x_i.outside | y_i.outside;
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_o = res_q;

endmodule

@@ rtl/core/mosaic_tile_pixel_mapper_core.sv @@
// Top level of the mosaic tile pixel mapper: registers, pipeline and valid chain.
//
// The mapper turns one mosaic coordinate into the supplying tile and the
// pixel inside it. It takes a new coordinate in every clock cycle, since
// busy_o stays low, and delivers each result with done_o high for exactly
// one cycle. The receiver cannot stall, so no result ever waits and the
// pipeline never holds. Each coordinate passes the stages in this order:
// the input register, the boundary compare that finds the tile index, the
// offset subtract and saturation, and the multiply that forms the linear
// source index. Tile boundaries are precomputed from the configuration in
// a register of their own, so a configuration write is in effect for any
// coordinate that starts in the cycle after the write. The configuration
// channel is always ready, and a write to an index beyond the six
// registers is dropped.
module mosaic_tile_pixel_mapper_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  output logic                             busy_o,
  input  logic [mtpm_pkg::COORD_W-1:0]     out_x_i,
  input  logic [mtpm_pkg::COORD_W-1:0]     out_y_i,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [mtpm_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [mtpm_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output logic                             done_o,
  output logic [mtpm_pkg::IDX_W-1:0]       tile_column_o,
  output logic [mtpm_pkg::IDX_W-1:0]       tile_row_o,
  output logic [mtpm_pkg::NUM_W-1:0]       tile_number_o,
  output logic [mtpm_pkg::OFF_W-1:0]       source_x_o,
  output logic [mtpm_pkg::OFF_W-1:0]       source_y_o,
  output logic [mtpm_pkg::SIDX_W-1:0]      source_index_o,
  output logic                             outside_mosaic_o
);

  // Raw configuration registers, reset to the documented defaults.
  logic [mtpm_pkg::SIZE_W-1:0] tile_width_q, tile_height_q;
  logic [mtpm_pkg::OV_W-1:0]   overlap_h_q, overlap_v_q;
  logic [mtpm_pkg::CNT_W-1:0]  columns_q, rows_q;

  // One valid bit per stage: input, index, offset, result.
  logic [3:0] vld_d, vld_q;

  logic [mtpm_pkg::COORD_W-1:0] x_q, y_q;
  logic                         accept;

  mtpm_pkg::axis_cfg_t cfg_x, cfg_y;
  mtpm_pkg::axis_res_t res_x, res_y;
  mtpm_pkg::result_t   res;

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start_i && !busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tile_width_q  <= mtpm_pkg::SIZE_W'(640);
      tile_height_q <= mtpm_pkg::SIZE_W'(480);
      overlap_h_q   <= '0;
      overlap_v_q   <= '0;
      columns_q     <= mtpm_pkg::CNT_W'(1);
      rows_q        <= mtpm_pkg::CNT_W'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (mtpm_pkg::cfg_reg_e'(cfg_index_i))
        mtpm_pkg::CFG_TILE_WIDTH:  tile_width_q  <= cfg_data_i;
        mtpm_pkg::CFG_TILE_HEIGHT: tile_height_q <= cfg_data_i;
        mtpm_pkg::CFG_OVERLAP_H:   overlap_h_q   <= cfg_data_i[mtpm_pkg::OV_W-1:0];
        mtpm_pkg::CFG_OVERLAP_V:   overlap_v_q   <= cfg_data_i[mtpm_pkg::OV_W-1:0];
        mtpm_pkg::CFG_COLUMNS:     columns_q     <= cfg_data_i[mtpm_pkg::CNT_W-1:0];
        mtpm_pkg::CFG_ROWS:        rows_q        <= cfg_data_i[mtpm_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign vld_d = {vld_q[2:0], accept};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // The input register captures a coordinate only on its transfer.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      x_q <= out_x_i;
      y_q <= out_y_i;
    end
  end

  mtpm_axis_cfg u_cfg_x (
    .clk_i       (clk_i),
    .size_raw_i  (tile_width_q),
    .ov_raw_i    (overlap_h_q),
    .count_raw_i (columns_q),
    .cfg_o       (cfg_x)
  );

  mtpm_axis_cfg u_cfg_y (
    .clk_i       (clk_i),
    .size_raw_i  (tile_height_q),
    .ov_raw_i    (overlap_v_q),
    .count_raw_i (rows_q),
    .cfg_o       (cfg_y)
  );

  mtpm_axis_map u_map_x (
    .clk_i   (clk_i),
    .cfg_i   (cfg_x),
    .coord_i (x_q),
    .res_o   (res_x)
  );

  mtpm_axis_map u_map_y (
    .clk_i   (clk_i),
    .cfg_i   (cfg_y),
    .coord_i (y_q),
    .res_o   (res_y)
  );

  mtpm_index u_index (
    .clk_i   (clk_i),
    .x_i     (res_x),
    .y_i     (res_y),
    .cfg_x_i (cfg_x),
    .res_o   (res)
  );

  assign done_o           = vld_q[3];
  assign tile_column_o    = res.tile_column;
  assign tile_row_o       = res.tile_row;
  assign tile_number_o    = res.tile_number;
  assign source_x_o       = res.source_x;
  assign source_y_o       = res.source_y;
  assign source_index_o   = res.source_index;
  assign outside_mosaic_o = res.outside_mosaic;

endmodule

@@ rtl/core/mtpm_checker.sv @@
// Port-level checker of the mosaic tile pixel mapper and its bind to the top level.
`include "mosaic_tile_pixel_mapper_core_assert.svh"

module mtpm_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          start_i,
  input logic                          busy_o,
  input logic [mtpm_pkg::COORD_W-1:0]  out_x_i,
  input logic [mtpm_pkg::COORD_W-1:0]  out_y_i,
  input logic                          done_o,
  input logic [mtpm_pkg::IDX_W-1:0]    tile_column_o,
  input logic [mtpm_pkg::IDX_W-1:0]    tile_row_o,
  input logic [mtpm_pkg::OFF_W-1:0]    source_x_o,
  input logic [mtpm_pkg::OFF_W-1:0]    source_y_o,
  input logic [mtpm_pkg::SIDX_W-1:0]   source_index_o,
  input logic                          outside_mosaic_o
);

  // Every transfer comes out as a result, and nothing else does.
  `MTPM_ASSERT(a_latency, clk_i, rst_ni, (start_i && !busy_o) |-> ##4 done_o)
  `MTPM_ASSERT_IMPLIES(a_no_extra, clk_i, rst_ni, done_o, $past(start_i && !busy_o, 4))

  // Inside the mosaic, the first column and row pass the coordinate through.
  `MTPM_ASSERT_IMPLIES(a_first_col, clk_i, rst_ni, done_o && !outside_mosaic_o && (tile_column_o == 4'd0), ({4'd0, source_x_o} == $past(out_x_i, 4)))
  `MTPM_ASSERT_IMPLIES(a_first_row, clk_i, rst_ni, done_o && !outside_mosaic_o && (tile_row_o == 4'd0), ({4'd0, source_y_o} == $past(out_y_i, 4)))

  // On the top row of a tile the linear index is the column alone.
  `MTPM_ASSERT_IMPLIES(a_row_zero_index, clk_i, rst_ni, done_o && (source_y_o == 12'd0), (source_index_o == {12'd0, source_x_o}))

endmodule

bind mosaic_tile_pixel_mapper_core mtpm_checker u_mtpm_checker (.*);
